// ----- src/mac_pkg.sv -----
// Shared types, constants and the div255 helper function for the masked alpha compositor.
// No dependencies; imported by mac_lane and masked_alpha_compositor_core.
`default_nettype none

package mac_pkg;

   localparam int ChanWidth = 8;
   localparam int SumWidth  = 2 * ChanWidth;
   localparam int OpWidth   = 17;
   localparam int NumLanes  = 4;
   localparam int CoverLane = 3;

   localparam logic [ChanWidth-1:0] ChanMax = '1;

   typedef logic [ChanWidth-1:0] chan_type;
   typedef logic [SumWidth-1:0]  sum_type;

   // How the current item is to be composited.
   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_REPLACE,
      MODE_FULL,
      MODE_OPACITY
   } mode_type;

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      CSR_REPLACE_LAYER = 1'b0,
      CSR_OPACITY       = 1'b1
   } csr_index_type;

   localparam logic [OpWidth-1:0] OpacityReset = 17'h10000;

   // Exact floor(x / 255) for any x up to 255 * 255, without a divider.
   function automatic chan_type div255(input sum_type x);
      logic [SumWidth:0] t;
      t = {1'b0, x} + (SumWidth+1)'(x[SumWidth-1:ChanWidth]) + (SumWidth+1)'(1);
      return t[SumWidth-1:ChanWidth];
   endfunction

endpackage

`default_nettype wire

// ----- src/mac_lane.sv -----
// One colour lane of the blend: under * (255 - w) + layer * w.
// Depends on mac_pkg for the channel and sum types.
`default_nettype none

module mac_lane
   import mac_pkg::*;
(
   input  chan_type under,
   input  chan_type layer,
   input  chan_type weight,
   output sum_type  sum
);

   sum_type under_prod;
   sum_type layer_prod;

   // Two 8x8 products; their sum never exceeds 255 * 255, so it fits 16 bits.
   assign under_prod = {{ChanWidth{1'b0}}, under} * {{ChanWidth{1'b0}}, ChanMax - weight};
   assign layer_prod = {{ChanWidth{1'b0}}, layer} * {{ChanWidth{1'b0}}, weight};
   assign sum        = under_prod + layer_prod;

endmodule

`default_nettype wire

// ----- src/masked_alpha_compositor_core.sv -----
// Masked alpha compositor, top level: three-stage pipeline ending in the output register.
// An item passes the stage 1, stage 2 and output registers in turn; throughput is one
// item per cycle while rsp_ready allows, set by the single weight multiplier and the
// per-lane multiply-add. Each stage advances whenever the stage after it is empty or
// moving, so bubbles fill. Reset (synchronous, active high) empties the pipeline, clears
// replace_layer and sets opacity to 65536. Depends on mac_pkg and mac_lane.
`default_nettype none

module masked_alpha_compositor_core
   import mac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_write,
   input  wire logic [0:0]           csr_index,
   input  wire logic [OpWidth-1:0]   csr_data,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ChanWidth-1:0] req_layer_red,
   input  wire logic [ChanWidth-1:0] req_layer_green,
   input  wire logic [ChanWidth-1:0] req_layer_blue,
   input  wire logic [ChanWidth-1:0] req_layer_alpha,
   input  wire logic [ChanWidth-1:0] req_under_red,
   input  wire logic [ChanWidth-1:0] req_under_green,
   input  wire logic [ChanWidth-1:0] req_under_blue,
   input  wire logic [ChanWidth-1:0] req_under_cover,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ChanWidth-1:0]      rsp_out_red,
   output logic [ChanWidth-1:0]      rsp_out_green,
   output logic [ChanWidth-1:0]      rsp_out_blue,
   output logic [ChanWidth-1:0]      rsp_out_cover
);

   // Configuration registers. The user is to change them only while the block is idle, so
   // every item in flight sees the same values; the block itself does not enforce this.
   logic               replace_ff;
   logic [OpWidth-1:0] opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_ff <= 1'b0;
         opacity_ff <= OpacityReset;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_REPLACE_LAYER: replace_ff <= csr_data[0];
            CSR_OPACITY:       opacity_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   // Stage enables. A stage loads when it is empty or its contents move on.
   logic en1;
   logic en2;
   logic en3;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;

   assign en3       = !s3_valid_ff || rsp_ready;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: decide the mode and form the blend weight.
   // At full opacity (bit 16 set, i.e. 65536 or above) the weight is the mask
   // itself; otherwise it is the top byte of mask * opacity. The coverage lane
   // is blended as a colour whose layer value is 255.
   // ---------------------------------------------------------------------
   logic [ChanWidth+OpWidth-2:0] weight_prod;
   mode_type                     mode_in;
   chan_type                     weight_in;
   chan_type                     s1_layer_in [NumLanes];
   chan_type                     s1_under_in [NumLanes];

   mode_type s1_mode_ff;
   chan_type s1_weight_ff;
   chan_type s1_layer_ff [NumLanes];
   chan_type s1_under_ff [NumLanes];

   assign weight_prod = {{(OpWidth-1){1'b0}}, req_layer_alpha} *
                        {{ChanWidth{1'b0}}, opacity_ff[OpWidth-2:0]};

   always_comb begin
      if (replace_ff) begin
         mode_in = MODE_REPLACE;
      end else if (req_layer_alpha == '0) begin
         mode_in = MODE_PASS;
      end else if (opacity_ff[OpWidth-1]) begin
         mode_in = MODE_FULL;
      end else begin
         mode_in = MODE_OPACITY;
      end

      weight_in = opacity_ff[OpWidth-1] ? req_layer_alpha
                                        : weight_prod[ChanWidth+OpWidth-2:OpWidth-1];

      s1_layer_in[0]         = req_layer_red;
      s1_layer_in[1]         = req_layer_green;
      s1_layer_in[2]         = req_layer_blue;
      s1_layer_in[CoverLane] = ChanMax;
      s1_under_in[0]         = req_under_red;
      s1_under_in[1]         = req_under_green;
      s1_under_in[2]         = req_under_blue;
      s1_under_in[CoverLane] = req_under_cover;
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         s1_mode_ff   <= mode_in;
         s1_weight_ff <= weight_in;
         s1_layer_ff  <= s1_layer_in;
         s1_under_ff  <= s1_under_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: weighted sum in each of the four lanes.
   // ---------------------------------------------------------------------
   sum_type  sum_in [NumLanes];

   mode_type s2_mode_ff;
   chan_type s2_layer_ff [NumLanes];
   chan_type s2_under_ff [NumLanes];
   sum_type  s2_sum_ff   [NumLanes];

   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      mac_lane u_lane (
         .under  (s1_under_ff[i]),
         .layer  (s1_layer_ff[i]),
         .weight (s1_weight_ff),
         .sum    (sum_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid_ff) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_layer_ff <= s1_layer_ff;
         s2_under_ff <= s1_under_ff;
         s2_sum_ff   <= sum_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale and select into the output register.
   // Colours divide by 255 at full opacity and by 256 on the opacity path;
   // coverage always divides by 255. A zero mask passes the pixel beneath
   // through, and replace mode copies the layer with coverage 255.
   // ---------------------------------------------------------------------
   chan_type out_in [NumLanes];
   chan_type out_ff [NumLanes];

   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         case (s2_mode_ff)
            MODE_PASS:    out_in[i] = s2_under_ff[i];
            MODE_REPLACE: out_in[i] = s2_layer_ff[i];
            MODE_FULL:    out_in[i] = div255(s2_sum_ff[i]);
            default: begin
               out_in[i] = (i == CoverLane) ? div255(s2_sum_ff[i])
                                            : s2_sum_ff[i][SumWidth-1:ChanWidth];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_cover = out_ff[CoverLane];

endmodule

`default_nettype wire

// ----- sim/tb_masked_alpha_compositor_core.sv -----
// Self-checking testbench for masked_alpha_compositor_core: directed and random pixels,
// register changes between phases and back-pressure on both channels.
// Depends on mac_pkg and the core RTL only.

module tb_masked_alpha_compositor_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mac_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int HoldCycles   = 120;
   localparam int SettleCycles = 8;
   localparam int RandomPhases = 12;
   localparam int PhaseItems   = 120;
   localparam int PrintLimit   = 40;

   // One input item: the layer pixel and the accumulated pixel beneath it.
   typedef struct packed {
      chan_type layer_red;
      chan_type layer_green;
      chan_type layer_blue;
      chan_type layer_alpha;
      chan_type under_red;
      chan_type under_green;
      chan_type under_blue;
      chan_type under_coverage;
   } pixel_item_type;

   // One result item: the new accumulated pixel.
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type coverage;
   } blended_pixel_type;

   logic                clock;
   logic                reset;
   logic                csr_write;
   logic [0:0]          csr_index;
   logic [OpWidth-1:0]  csr_data;
   logic                req_valid;
   logic                req_ready;
   pixel_item_type      req_pixel;
   logic                rsp_valid;
   logic                rsp_ready;
   chan_type            rsp_out_red;
   chan_type            rsp_out_green;
   chan_type            rsp_out_blue;
   chan_type            rsp_out_cover;

   // Shadow copy of the block's registers, updated as each write lands.
   logic                cfg_replace;
   logic [OpWidth-1:0]  cfg_opacity;

   blended_pixel_type   pending_pixels[$];
   int                  error_count;
   int                  pixels_accepted;
   int                  pixels_checked;
   int                  register_writes;
   int                  cycle_count;
   bit                  idle_enabled;
   bit                  hold_request;

   masked_alpha_compositor_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_layer_red   (req_pixel.layer_red),
      .req_layer_green (req_pixel.layer_green),
      .req_layer_blue  (req_pixel.layer_blue),
      .req_layer_alpha (req_pixel.layer_alpha),
      .req_under_red   (req_pixel.under_red),
      .req_under_green (req_pixel.under_green),
      .req_under_blue  (req_pixel.under_blue),
      .req_under_cover (req_pixel.under_coverage),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_cover   (rsp_out_cover)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here rather than running for ever.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_pixels.size());
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Weighted mix of two channels, truncating division by 255.
   function automatic chan_type mix_by_255(input chan_type under, input chan_type layer,
                                           input int unsigned w);
      int unsigned total;
      total = under * (255 - w) + layer * w;
      return chan_type'(total / 255);
   endfunction

   // The same mix with the cheaper division by 256 used on the opacity path.
   function automatic chan_type mix_by_256(input chan_type under, input chan_type layer,
                                           input int unsigned w);
      int unsigned total;
      total = under * (255 - w) + layer * w;
      return chan_type'(total / 256);
   endfunction

   // Works out the new accumulated pixel from the registers as they now stand.
   function automatic blended_pixel_type composite_pixel(input pixel_item_type px);
      blended_pixel_type res;
      int unsigned       m;
      int unsigned       op;
      int unsigned       w;
      m  = px.layer_alpha;
      // Opacity above one is clamped, which lands it on the exact full-opacity path.
      op = (cfg_opacity > OpacityReset) ? OpacityReset : cfg_opacity;
      if (cfg_replace) begin
         // A layer without a mask simply overwrites, whatever its alpha says.
         res = {px.layer_red, px.layer_green, px.layer_blue, ChanMax};
      end else if (m == 0) begin
         res = {px.under_red, px.under_green, px.under_blue, px.under_coverage};
      end else if (op == OpacityReset) begin
         res.red      = mix_by_255(px.under_red,      px.layer_red,   m);
         res.green    = mix_by_255(px.under_green,    px.layer_green, m);
         res.blue     = mix_by_255(px.under_blue,     px.layer_blue,  m);
         res.coverage = mix_by_255(px.under_coverage, ChanMax,        m);
      end else begin
         // Partial opacity scales the mask first; colours then divide by 256 while
         // coverage still divides by 255. Zero opacity gives a weight of nought here.
         w = (m * op) >> 16;
         res.red      = mix_by_256(px.under_red,      px.layer_red,   w);
         res.green    = mix_by_256(px.under_green,    px.layer_green, w);
         res.blue     = mix_by_256(px.under_blue,     px.layer_blue,  w);
         res.coverage = mix_by_255(px.under_coverage, ChanMax,        w);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (error_count < PrintLimit)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic check_channel(input string name, input chan_type got, input chan_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, wanted %0d", name, got, want));
   endtask

   // Both channels are sampled on the rising edge. An accepted item queues its
   // prediction, using the registers of the moment; an accepted result is matched
   // against the oldest prediction still waiting.
   always @(posedge clock) begin
      blended_pixel_type want;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            pending_pixels.push_back(composite_pixel(req_pixel));
            pixels_accepted++;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("result item arrived with nothing outstanding");
            end else begin
               want = pending_pixels.pop_front();
               check_channel("out_red",   rsp_out_red,   want.red);
               check_channel("out_green", rsp_out_green, want.green);
               check_channel("out_blue",  rsp_out_blue,  want.blue);
               check_channel("out_cover", rsp_out_cover, want.coverage);
               pixels_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result side. Ready changes on the falling edge only. A requested hold-off is
   // counted out here, in cycles, while the sender keeps offering items; otherwise
   // ready drops in short random bursts whenever idling is enabled.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus tasks. Each one starts and finishes just after a falling edge, so
   // that no signal is assigned twice within one time step.
   // ---------------------------------------------------------------------------

   // Offers one item and waits for it to be taken. Valid is left high afterwards,
   // so back-to-back items go through at the full rate.
   task automatic send_pixel(input pixel_item_type px);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Register writes happen only with the pipeline empty, so the shadow copy can
   // be updated straight after the write edge.
   task automatic write_register(input csr_index_type index, input logic [OpWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_REPLACE_LAYER)
         cfg_replace = value[0];
      else
         cfg_opacity = value;
      register_writes++;
      @(negedge clock);
   endtask

   // Stops offering items, waits for every outstanding result, then lets the block sit
   // idle before anything else happens.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Fully random pixel, with transparent and opaque masks made more likely.
   function automatic pixel_item_type random_pixel();
      pixel_item_type px;
      px = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       px.layer_alpha = '0;
         1:       px.layer_alpha = ChanMax;
         default: ;
      endcase
      return px;
   endfunction

   // Opacity settings weighted towards the edges of the register's range.
   function automatic logic [OpWidth-1:0] random_opacity();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return OpacityReset;
         2:       return OpWidth'(OpacityReset + 1);
         3:       return '1;
         4:       return OpWidth'(OpacityReset - 1);
         5:       return OpWidth'($urandom_range(65537, 131071));
         default: return OpWidth'($urandom_range(1, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Registers as they come out of reset: blend at full opacity.
   task automatic test_reset_defaults();
      // Transparent mask: the pixel beneath must come through untouched.
      send_pixel({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40});
      // Opaque mask at full opacity gives the layer colour and full coverage.
      send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      // Weakest and strongest partial masks against opposite extremes.
      send_pixel({8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255});
      send_pixel({8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 8'd255, 8'd0});
      send_pixel({8'd128, 8'd64, 8'd32, 8'd128, 8'd16, 8'd8, 8'd4, 8'd2});
      settle_pipeline();
   endtask

   // A layer with no mask replaces the pixel for any alpha, transparent included.
   task automatic test_replace_mode();
      write_register(CSR_REPLACE_LAYER, OpWidth'(1));
      send_pixel({8'd12, 8'd34, 8'd56, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0});
      send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255});
      send_pixel({8'd0, 8'd0, 8'd0, 8'd1, 8'd200, 8'd150, 8'd100, 8'd50});
      send_pixel({8'd99, 8'd0, 8'd255, 8'd100, 8'd1, 8'd2, 8'd3, 8'd4});
      settle_pipeline();
      write_register(CSR_REPLACE_LAYER, OpWidth'(0));
   endtask

   task automatic opacity_case(input logic [OpWidth-1:0] level);
      write_register(CSR_OPACITY, level);
      send_pixel({8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd64, 8'd0});
      send_pixel({8'd0, 8'd255, 8'd255, 8'd1, 8'd255, 8'd0, 8'd255, 8'd128});
      send_pixel(random_pixel());
      settle_pipeline();
   endtask

   // Zero opacity still darkens by the 255/256 factor; opacity above one must
   // behave exactly as full opacity; the two just below and at half also.
   task automatic test_opacity_edges();
      opacity_case('0);
      opacity_case('1);
      opacity_case(OpWidth'(OpacityReset - 1));
      opacity_case(OpacityReset >> 1);
   endtask

   // The bulk of the run: random pixels under a fresh pair of register values each
   // phase, with idling on both sides in most phases and absent in a few.
   task automatic test_random_settings();
      repeat (RandomPhases) begin
         write_register(CSR_REPLACE_LAYER,
                        OpWidth'(($urandom_range(0, 5) == 0) ? 1 : 0));
         write_register(CSR_OPACITY, random_opacity());
         idle_enabled = ($urandom_range(0, 3) != 0);
         repeat (PhaseItems) send_pixel(random_pixel());
         settle_pipeline();
      end
   endtask

   // The result side holds off for a long stretch while items keep coming, so
   // the pipeline fills and has to refuse further input.
   task automatic test_backpressure();
      idle_enabled = 1'b0;
      write_register(CSR_OPACITY, random_opacity());
      hold_request = 1'b1;
      repeat (40) send_pixel(random_pixel());
      settle_pipeline();
   endtask

   // Closing stretch with no idling at all: one item per clock throughout.
   task automatic test_full_rate();
      idle_enabled = 1'b0;
      write_register(CSR_OPACITY, OpWidth'($urandom_range(1, 65535)));
      repeat (150) send_pixel(random_pixel());
      settle_pipeline();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_pixel       = '0;
      cfg_replace     = 1'b0;
      cfg_opacity     = OpacityReset;
      error_count     = 0;
      pixels_accepted = 0;
      pixels_checked  = 0;
      register_writes = 0;
      idle_enabled    = 1'b1;
      hold_request    = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_replace_mode();
      test_opacity_edges();
      test_random_settings();
      test_backpressure();
      test_full_rate();

      if (pending_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));

      $display("Composited %0d items and checked %0d results over %0d register writes,",
               pixels_accepted, pixels_checked, register_writes);
      $display("covering replace, transparent, full and partial opacity, and a %0d-cycle stall.",
               HoldCycles);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
